// File: design/linear_probe_symbol_table_core_macros.svh
// Assertion macros for the linear-probe symbol table core.
// Included by modules that carry concurrent checks; needs clock and reset in scope.
`ifndef LINEAR_PROBE_SYMBOL_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_SYMBOL_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LPST_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define LPST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lpst_pkg.sv
// Shared types and constants for the linear-probe symbol table core.
// No dependencies; imported by linear_probe_symbol_table_core.
`timescale 1ns / 1ps

package lpst_pkg;

   // Field widths
   localparam int KEY_W  = 32;
   localparam int REF_W  = 16;
   localparam int LEN_W  = 8;
   localparam int STAT_W = 3;
   localparam int SLOT_W = 6;

   // Default table size
   localparam int TABLE_DEPTH_DEF = 64;

   // Command codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_MISS     = 3'd0;
   localparam logic [STAT_W-1:0] ST_HIT      = 3'd1;
   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_INVALID  = 3'd4;

   // Request beat
   typedef struct packed {
      logic             command;
      logic [KEY_W-1:0] key_hash;
      logic [REF_W-1:0] name_ref;
      logic [LEN_W-1:0] name_length;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot_index;
      logic [REF_W-1:0]  found_name_ref;
      logic [LEN_W-1:0]  found_name_length;
   } rsp_type;

   // One table slot as stored in the slot memory
   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
      logic [REF_W-1:0] handle;
      logic [LEN_W-1:0] len;
   } entry_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_MOD   = 6'b000100,
      S_FETCH = 6'b001000,
      S_PROBE = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

endpackage

// File: design/linear_probe_symbol_table_core.sv
// Linear-probe symbol table core: slot memory, modulo unit and probe sequencer.
// Depends on lpst_pkg and linear_probe_symbol_table_core_macros.svh.
`timescale 1ns / 1ps
//
// Usage
//   req channel (req_valid/req_ready/req_data): one lookup or insert beat
//   carrying a 32-bit key hash, a name handle and a name length.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): one result beat per command.
//   One command at a time; req_ready is high only while the sequencer idles.
// Sequence
//   Key hash 0: straight from accept to the emit state.
//   Otherwise key mod TABLE_DEPTH is worked out (reciprocal multiply,
//   quotient fix-up, remainder), the first slot read is issued, slots are
//   probed in turn (1 to TABLE_DEPTH, one memory read port) and the
//   output register is loaded; the sequencer then returns to idle before
//   the next accept.
// Reset
//   The slot memory is swept clear, one slot per cycle, over all TABLE_DEPTH
//   slots; req_ready stays low during the sweep.
// Stalls
//   A waiting result sits in the output register while a new command is
//   accepted; the next result waits in the sequencer until rsp_ready frees it.
//
`include "linear_probe_symbol_table_core_macros.svh"

module linear_probe_symbol_table_core
   import lpst_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [IDX_W-1:0] DEPTH_LO = IDX_W'(TABLE_DEPTH);
   localparam int QUO_SH = IDX_W - 1;

   // Reciprocal for division by the depth: floor(2^32 * (2^l - d) / d) + 1
   localparam logic [2*KEY_W-1:0] RECIP_NUM =
      {{KEY_W{1'b0}}, KEY_W'((1 << IDX_W) - TABLE_DEPTH)} << KEY_W;
   localparam logic [2*KEY_W-1:0] RECIP_FULL =
      RECIP_NUM / (2*KEY_W)'(TABLE_DEPTH) + 1'b1;
   localparam logic [KEY_W-1:0] RECIP_M = RECIP_FULL[KEY_W-1:0];

   // Modulo phases
   localparam logic [1:0] PH_MUL = 2'd0;
   localparam logic [1:0] PH_QUO = 2'd1;

   // Slot memory
   entry_type slot_mem [TABLE_DEPTH];

   // Control registers
   state_type          state_ff, state_in;
   logic [1:0]         mod_phase_ff, mod_phase_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   req_type            req_hold_ff, req_hold_in;
   logic [2*KEY_W-1:0] prod_ff, prod_in;
   logic [KEY_W-1:0]   quo_ff, quo_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   entry_type          rd_data_ff;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Memory write port
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;

   // Modulo unit and probe helpers
   logic [2*KEY_W-1:0] mod_prod;
   logic [KEY_W-1:0]   mul_hi;
   logic [KEY_W-1:0]   quo_sum;
   logic [KEY_W-1:0]   mod_quo;
   logic [IDX_W-1:0]   quo_scaled;
   logic [IDX_W-1:0]   mod_rem;
   logic [IDX_W-1:0]   rd_idx_inc;
   logic [IDX_W-1:0]   chk_idx_inc;
   logic [IDX_W+SLOT_W-1:0] chk_wide;
   logic [SLOT_W-1:0]  chk_slot;
   logic               slot_empty;
   logic               slot_match;
   logic               req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Key mod depth: multiply by the reciprocal, fix up the quotient,
   // then subtract quotient times depth in the low index bits
   assign mod_prod   = {{KEY_W{1'b0}}, req_hold_ff.key_hash} * {{KEY_W{1'b0}}, RECIP_M};
   assign mul_hi     = prod_ff[2*KEY_W-1:KEY_W];
   assign quo_sum    = mul_hi + ((req_hold_ff.key_hash - mul_hi) >> 1);
   assign mod_quo    = quo_sum >> QUO_SH;
   assign quo_scaled = quo_ff[IDX_W-1:0] * DEPTH_LO;
   assign mod_rem    = req_hold_ff.key_hash[IDX_W-1:0] - quo_scaled;

   // Wrapping slot increments
   assign rd_idx_inc  = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
   assign chk_idx_inc = (clr_idx_ff == LAST_IDX) ? '0 : clr_idx_ff + 1'b1;

   // Slot number reported modulo 64
   assign chk_wide = {{SLOT_W{1'b0}}, chk_idx_ff};
   assign chk_slot = chk_wide[SLOT_W-1:0];

   // Probe compare on the slot read last cycle
   assign slot_empty = !rd_data_ff.used;
   assign slot_match = rd_data_ff.used && (rd_data_ff.key == req_hold_ff.key_hash);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mod_phase_in = mod_phase_ff;
      step_in      = step_ff;
      clr_idx_in   = clr_idx_ff;
      req_hold_in  = req_hold_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rd_idx_in    = rd_idx_ff;
      chk_idx_in   = chk_idx_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = chk_idx_ff;
      mem_wdata    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = chk_idx_inc;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               req_hold_in  = req_data;
               mod_phase_in = PH_MUL;
               if (req_data.key_hash == '0) begin
                  res_in   = '{status: ST_INVALID, slot_index: '0,
                               found_name_ref: '0, found_name_length: '0};
                  state_in = S_EMIT;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            mod_phase_in = mod_phase_ff + 1'b1;
            if (mod_phase_ff == PH_MUL) begin
               prod_in = mod_prod;
            end else if (mod_phase_ff == PH_QUO) begin
               quo_in = mod_quo;
            end else begin
               rd_idx_in    = mod_rem;
               step_in      = '0;
               mod_phase_in = PH_MUL;
               state_in     = S_FETCH;
            end
         end
         S_FETCH: begin
            // first slot read issued this cycle
            chk_idx_in = rd_idx_ff;
            rd_idx_in  = rd_idx_inc;
            state_in   = S_PROBE;
         end
         S_PROBE: begin
            if (slot_empty) begin
               if (req_hold_ff.command == CMD_INSERT) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{used: 1'b1, key: req_hold_ff.key_hash,
                                handle: req_hold_ff.name_ref,
                                len: req_hold_ff.name_length};
                  res_in    = '{status: ST_INSERTED, slot_index: chk_slot,
                                found_name_ref: req_hold_ff.name_ref,
                                found_name_length: req_hold_ff.name_length};
               end else begin
                  res_in    = '{status: ST_MISS, slot_index: chk_slot,
                                found_name_ref: '0, found_name_length: '0};
               end
               state_in = S_EMIT;
            end else if (slot_match) begin
               res_in   = '{status: ST_HIT, slot_index: chk_slot,
                            found_name_ref: rd_data_ff.handle,
                            found_name_length: rd_data_ff.len};
               state_in = S_EMIT;
            end else if (step_ff == LAST_IDX) begin
               res_in   = '{status: ST_FULL, slot_index: '0,
                            found_name_ref: '0, found_name_length: '0};
               state_in = S_EMIT;
            end else begin
               chk_idx_in = rd_idx_ff;
               rd_idx_in  = rd_idx_inc;
               step_in    = step_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mod_phase_ff <= PH_MUL;
         step_ff      <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_phase_ff <= mod_phase_in;
         step_ff      <= step_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath
   always_ff @(posedge clock) begin
      req_hold_ff <= req_hold_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[rd_idx_ff];
   end

   // Checks
   `LPST_ASSERT_NEXT(a_busy_after_accept, req_fire, state_ff != S_IDLE,
      "sequencer still idle after accepting a command")
   `LPST_ASSERT_IMPL(a_write_states, mem_we, (state_ff == S_PROBE) || (state_ff == S_CLEAR),
      "slot memory written outside the clear sweep or a probe")
   `LPST_ASSERT_IMPL(a_no_accept_clear, state_ff == S_CLEAR, !req_ready,
      "command accepted during the clear sweep")
   `LPST_ASSERT_IMPL(a_rsp_from_emit, !$past(rsp_valid_ff) && rsp_valid_ff,
      $past(state_ff) == S_EMIT, "response raised outside the emit state")

endmodule

// File: tb/linear_probe_symbol_table_core_tb.sv
// Self-checking testbench for linear_probe_symbol_table_core: directed and random
// lookup/insert beats, checked against an in-bench model of the probed slot table.
// Depends on lpst_pkg and the core RTL.
`timescale 1ns / 1ps

module linear_probe_symbol_table_core_tb;
   import lpst_pkg::*;

   localparam int unsigned TBL_DEPTH      = 64;
   localparam int unsigned RANDOM_CMDS    = 1750;
   // The receiver hold-off below is the longest quiet spell, so the limit
   // sits well above it.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_AT        = 300;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned QUIET_FROM     = 600;
   localparam int unsigned QUIET_TO       = 900;
   localparam int unsigned DRAIN_CYCLES   = TBL_DEPTH + 40;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Model copy of the slot table
   logic [KEY_W-1:0] table_key  [TBL_DEPTH];
   logic             table_used [TBL_DEPTH];
   logic [REF_W-1:0] table_ref  [TBL_DEPTH];
   logic [LEN_W-1:0] table_len  [TBL_DEPTH];

   req_type     cmd_backlog[$];
   rsp_type     predicted_results[$];
   rsp_type     oldest_result;
   int unsigned cmds_sent;
   int unsigned results_checked;
   int unsigned mismatch_count;
   int unsigned status_tally [0:4];
   int unsigned hold_left;
   bit          hold_done;
   int unsigned quiet_cycles;

   linear_probe_symbol_table_core #(
      .TABLE_DEPTH(TBL_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Probe the model table for one command and apply an insert
   function automatic rsp_type probe_table(req_type cmd);
      rsp_type     res;
      int unsigned idx;
      int unsigned step;
      res = '0;
      if (cmd.key_hash == '0) begin
         res.status = ST_INVALID;
         return res;
      end
      idx = cmd.key_hash % TBL_DEPTH;
      for (step = 0; step < TBL_DEPTH; step++) begin
         if (!table_used[idx]) begin
            res.slot_index = idx[SLOT_W-1:0];
            if (cmd.command == CMD_INSERT) begin
               table_used[idx]       = 1'b1;
               table_key[idx]        = cmd.key_hash;
               table_ref[idx]        = cmd.name_ref;
               table_len[idx]        = cmd.name_length;
               res.status            = ST_INSERTED;
               res.found_name_ref    = cmd.name_ref;
               res.found_name_length = cmd.name_length;
            end else begin
               res.status = ST_MISS;
            end
            return res;
         end
         if (table_key[idx] == cmd.key_hash) begin
            res.status            = ST_HIT;
            res.slot_index        = idx[SLOT_W-1:0];
            res.found_name_ref    = table_ref[idx];
            res.found_name_length = table_len[idx];
            return res;
         end
         idx = (idx + 1) % TBL_DEPTH;
      end
      res.status = ST_FULL;
      return res;
   endfunction

   function automatic void field_check(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic add_cmd(input logic op, input logic [KEY_W-1:0] key,
                          input logic [REF_W-1:0] nref, input logic [LEN_W-1:0] nlen);
      req_type cmd;
      cmd.command     = op;
      cmd.key_hash    = key;
      cmd.name_ref    = nref;
      cmd.name_length = nlen;
      cmd_backlog.push_back(cmd);
   endtask

   // Random keys, most likely not yet stored; half land in a few home slots to build long chains
   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = $urandom();
      if ($urandom_range(1, 0) == 1) begin
         if ($urandom_range(3, 0) == 0) k[5:0] = 6'($urandom_range(63, 60));
         else k[5:0] = 6'($urandom_range(7, 0));
      end
      return k;
   endfunction

   function automatic int unsigned extreme_or_random(int unsigned maxv);
      int unsigned pick;
      pick = $urandom_range(9, 0);
      if (pick == 0) return 0;
      if (pick == 1) return maxv;
      return $urandom_range(maxv, 0);
   endfunction

   // Stimulus, then end-of-run bookkeeping
   initial begin
      logic [KEY_W-1:0] known_keys[$];
      logic [KEY_W-1:0] key;
      int unsigned      n;
      int unsigned      pick;
      int unsigned      total_cmds;

      for (n = 0; n < TBL_DEPTH; n++) begin
         table_used[n] = 1'b0;
         table_key[n]  = '0;
         table_ref[n]  = '0;
         table_len[n]  = '0;
      end
      for (n = 0; n < 5; n++) status_tally[n] = 0;

      // Directed: invalid key, wrap from the top slot, collisions, duplicates
      add_cmd(CMD_LOOKUP, 32'h0000_0000, 16'hFFFF, 8'hFF);
      add_cmd(CMD_INSERT, 32'h0000_0000, 16'h0000, 8'h00);
      add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 8'h00);
      add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
      add_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 8'h00);
      add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 16'h1234, 8'h01);
      add_cmd(CMD_INSERT, 32'h0000_007F, 16'h0000, 8'h00);
      add_cmd(CMD_LOOKUP, 32'h0000_007F, 16'hFFFF, 8'hFF);
      add_cmd(CMD_INSERT, 32'h0000_0001, 16'hA5A5, 8'h5A);
      add_cmd(CMD_LOOKUP, 32'h0000_00BF, 16'h0000, 8'h00);
      add_cmd(CMD_INSERT, 32'h0000_0040, 16'h0001, 8'h80);
      add_cmd(CMD_LOOKUP, 32'h8000_0000, 16'h0000, 8'h00);
      add_cmd(CMD_INSERT, 32'h8000_0000, 16'h5A5A, 8'hA5);
      add_cmd(CMD_LOOKUP, 32'h0000_0001, 16'h0000, 8'h00);
      add_cmd(CMD_INSERT, 32'h0000_0001, 16'hFFFF, 8'hFF);
      known_keys = '{32'hFFFF_FFFF, 32'h0000_007F, 32'h0000_0001, 32'h0000_0040,
                     32'h8000_0000};

      // Random mix; new-key inserts are rare enough that the table fills late
      for (n = 0; n < RANDOM_CMDS; n++) begin
         pick = $urandom_range(99, 0);
         if (pick < 2) begin
            add_cmd(($urandom_range(1, 0) == 1) ? CMD_INSERT : CMD_LOOKUP, '0,
                    REF_W'(extreme_or_random(16'hFFFF)), LEN_W'(extreme_or_random(8'hFF)));
         end else if (pick < 7) begin
            key = fresh_key();
            known_keys.push_back(key);
            add_cmd(CMD_INSERT, key, REF_W'(extreme_or_random(16'hFFFF)),
                    LEN_W'(extreme_or_random(8'hFF)));
         end else if (pick < 27) begin
            add_cmd(CMD_LOOKUP, fresh_key(), REF_W'($urandom()), LEN_W'($urandom()));
         end else begin
            key = known_keys[$urandom_range(known_keys.size() - 1, 0)];
            add_cmd(pick < 40 ? CMD_INSERT : CMD_LOOKUP, key,
                    REF_W'(extreme_or_random(16'hFFFF)), LEN_W'(extreme_or_random(8'hFF)));
         end
      end
      total_cmds = cmd_backlog.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every result, then watch a while for stray beats
      while (results_checked < total_cmds) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predicted_results.size() != 0 || cmd_backlog.size() != 0) begin
         $display("%0t: outstanding commands mismatch, expected 0, got %0d", $time,
                  predicted_results.size() + cmd_backlog.size());
         mismatch_count++;
      end

      $display("Checked %0d result beats: %0d inserted, %0d hit/present, %0d miss,",
               results_checked, status_tally[ST_INSERTED], status_tally[ST_HIT],
               status_tally[ST_MISS]);
      $display("  %0d table full, %0d invalid key, %0d mismatches",
               status_tally[ST_FULL], status_tally[ST_INVALID], mismatch_count);
      if (mismatch_count == 0) begin
         $display("linear_probe_symbol_table_core_tb passed");
      end else begin
         $display("linear_probe_symbol_table_core_tb failed");
      end
      $finish;
   end

   // Request driver: predict on accept, then offer the next beat or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_results.push_back(probe_table(req_data));
            cmds_sent++;
         end
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 &&
                ((cmds_sent >= QUIET_FROM && cmds_sent < QUIET_TO) ||
                 $urandom_range(99, 0) >= 13)) begin
               req_data  <= cmd_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each beat, stall at random, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest_result = predicted_results.pop_front();
               field_check("status", oldest_result.status, rsp_data.status);
               field_check("slot_index", oldest_result.slot_index, rsp_data.slot_index);
               field_check("found_name_ref", oldest_result.found_name_ref,
                           rsp_data.found_name_ref);
               field_check("found_name_length", oldest_result.found_name_length,
                           rsp_data.found_name_length);
            end
            if (rsp_data.status <= ST_INVALID) status_tally[rsp_data.status]++;
            results_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (results_checked >= HOLD_AT && !hold_done) begin
            // long back-pressure so the core fills and drops req_ready
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (results_checked >= QUIET_FROM && results_checked < QUIET_TO) ||
                         ($urandom_range(99, 0) >= 13);
         end
      end
   end

   // Watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("linear_probe_symbol_table_core_tb failed");
            $finish;
         end
      end
   end

endmodule
